// ===== rtl/sled_pkg.sv =====
// ----------------------------------------------------------------------------
// sled_pkg
// Shared types and constants for the start/length/end byte deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package sled_pkg;

   localparam int BYTE_W = 8;

   typedef logic [BYTE_W-1:0] byte_type;
   typedef logic [1:0]        kind_type;

   // frame parser phase
   typedef enum logic [2:0] {
      PH_HUNT    = 3'd0,
      PH_TYPE    = 3'd1,
      PH_LENGTH  = 3'd2,
      PH_PAYLOAD = 3'd3,
      PH_TERM    = 3'd4
   } phase_type;

   // result kinds
   localparam kind_type KIND_DATA = 2'd0;
   localparam kind_type KIND_GOOD = 2'd1;
   localparam kind_type KIND_BAD  = 2'd2;

   // register indexes
   typedef logic csr_index_type;
   localparam csr_index_type CSR_START_BYTE = 1'b0;
   localparam csr_index_type CSR_END_BYTE   = 1'b1;

   localparam byte_type START_BYTE_RESET = 8'd2;
   localparam byte_type END_BYTE_RESET   = 8'd3;

endpackage

`default_nettype wire

// ===== rtl/sled_req_if.sv =====
// ----------------------------------------------------------------------------
// sled_req_if
// Received byte channel: valid/ready handshake with one byte of payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface sled_req_if;
   import sled_pkg::*;

   logic     valid;
   logic     ready;
   byte_type rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

// ===== rtl/sled_rsp_if.sv =====
// ----------------------------------------------------------------------------
// sled_rsp_if
// Result channel: payload bytes and frame end status.
// ----------------------------------------------------------------------------
`default_nettype none

interface sled_rsp_if;
   import sled_pkg::*;

   logic     valid;
   logic     ready;
   kind_type result_kind;
   byte_type frame_kind;
   byte_type payload_byte;
   byte_type byte_index;
   byte_type payload_length;

   modport source (output valid, output result_kind, output frame_kind,
                   output payload_byte, output byte_index, output payload_length,
                   input ready);
   modport sink   (input valid, input result_kind, input frame_kind,
                   input payload_byte, input byte_index, input payload_length,
                   output ready);
endinterface

`default_nettype wire

// ===== rtl/sof_length_eof_deframer.sv =====
// ----------------------------------------------------------------------------
// sof_length_eof_deframer
// Hunts for a start byte, takes type and length, emits each payload byte
// and then a good or bad terminator result.
// ----------------------------------------------------------------------------
//   channel   dir   content                                     handshake
//   req_ch    in    rx_byte                                     valid/ready
//   rsp_ch    out   result_kind, frame_kind, payload_byte,      valid/ready
//                   byte_index, payload_length
//   csr_*     in    csr_index 0 start_byte, 1 end_byte          write enable
//
// One byte per cycle sustained while results are taken. A byte is registered
// in the input register and its result in the output register. Reset returns
// the parser to hunting and loads 2 and 3 into the start and end byte
// registers. A stalled result holds the parser; the input register still
// takes one more byte behind it.
// ----------------------------------------------------------------------------
`default_nettype none

module sof_length_eof_deframer (
   input  wire                    clock,
   input  wire                    reset,
   sled_req_if.sink               req_ch,
   sled_rsp_if.source             rsp_ch,
   input  wire                    csr_we,
   input  wire sled_pkg::csr_index_type csr_index,
   input  wire sled_pkg::byte_type     csr_wdata
);
   import sled_pkg::*;

   // configuration
   byte_type  start_byte_ff, end_byte_ff;

   // input register
   logic      in_valid_ff;
   byte_type  in_byte_ff;

   // parser state
   phase_type phase_ff, phase_in;
   byte_type  held_kind_ff, held_kind_in;
   byte_type  held_length_ff, held_length_in;
   byte_type  bytes_left_ff, bytes_left_in;
   byte_type  next_index_ff, next_index_in;

   // result register
   logic      out_valid_ff, out_valid_in;
   kind_type  out_kind_ff, out_kind_in;
   byte_type  out_frame_ff, out_frame_in;
   byte_type  out_data_ff, out_data_in;
   byte_type  out_index_ff, out_index_in;
   byte_type  out_length_ff, out_length_in;

   logic      emit;
   logic      stage_go;

   // the parser moves when the result register is free or being emptied
   assign stage_go     = in_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || stage_go;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_byte_ff <= START_BYTE_RESET;
         end_byte_ff   <= END_BYTE_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_START_BYTE: start_byte_ff <= csr_wdata;
            CSR_END_BYTE:   end_byte_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         in_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         in_byte_ff <= req_ch.rx_byte;
      end
   end

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (stage_go) begin
         case (phase_ff)
            PH_TYPE:    phase_in = PH_LENGTH;
            PH_LENGTH:  phase_in = (in_byte_ff == '0) ? PH_TERM : PH_PAYLOAD;
            PH_PAYLOAD: phase_in = (bytes_left_ff == 8'd1) ? PH_TERM : PH_PAYLOAD;
            PH_TERM:    phase_in = PH_HUNT;
            default:    phase_in = (in_byte_ff == start_byte_ff) ? PH_TYPE : PH_HUNT;
         endcase
      end
   end

   // held fields and result
   always_comb begin
      held_kind_in   = held_kind_ff;
      held_length_in = held_length_ff;
      bytes_left_in  = bytes_left_ff;
      next_index_in  = next_index_ff;
      emit           = 1'b0;
      out_kind_in    = KIND_DATA;
      out_data_in    = '0;
      out_index_in   = '0;
      if (stage_go) begin
         case (phase_ff)
            PH_TYPE: begin
               held_kind_in = in_byte_ff;
            end
            PH_LENGTH: begin
               held_length_in = in_byte_ff;
               bytes_left_in  = in_byte_ff;
               next_index_in  = '0;
            end
            PH_PAYLOAD: begin
               emit          = 1'b1;
               out_kind_in   = KIND_DATA;
               out_data_in   = in_byte_ff;
               out_index_in  = next_index_ff;
               next_index_in = next_index_ff + 8'd1;
               bytes_left_in = bytes_left_ff - 8'd1;
            end
            PH_TERM: begin
               emit        = 1'b1;
               out_kind_in = (in_byte_ff == end_byte_ff) ? KIND_GOOD : KIND_BAD;
            end
            default: ;
         endcase
      end
      out_frame_in  = held_kind_ff;
      out_length_in = held_length_ff;
      out_valid_in  = emit || (out_valid_ff && !rsp_ch.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_HUNT;
         held_kind_ff   <= '0;
         held_length_ff <= '0;
         bytes_left_ff  <= '0;
         next_index_ff  <= '0;
         out_valid_ff   <= 1'b0;
      end else begin
         phase_ff       <= phase_in;
         held_kind_ff   <= held_kind_in;
         held_length_ff <= held_length_in;
         bytes_left_ff  <= bytes_left_in;
         next_index_ff  <= next_index_in;
         out_valid_ff   <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         out_kind_ff   <= out_kind_in;
         out_frame_ff  <= out_frame_in;
         out_data_ff   <= out_data_in;
         out_index_ff  <= out_index_in;
         out_length_ff <= out_length_in;
      end
   end

   assign rsp_ch.valid          = out_valid_ff;
   assign rsp_ch.result_kind    = out_kind_ff;
   assign rsp_ch.frame_kind     = out_frame_ff;
   assign rsp_ch.payload_byte   = out_data_ff;
   assign rsp_ch.byte_index     = out_index_ff;
   assign rsp_ch.payload_length = out_length_ff;

   // payload phase never runs with nothing left to count
   a_left_nonzero: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_PAYLOAD |-> bytes_left_ff != '0)
      else $error("payload phase with zero bytes left");

   // a data result always lies inside the declared length
   a_index_range: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.result_kind == KIND_DATA
         |-> rsp_ch.byte_index < rsp_ch.payload_length)
      else $error("payload index beyond declared length");

   // type byte is always followed by the length phase
   a_type_then_len: assert property (@(posedge clock) disable iff (reset)
      stage_go && phase_ff == PH_TYPE |=> phase_ff == PH_LENGTH)
      else $error("type byte not followed by length phase");

   // no result without a transfer through the parser or a held result
   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      !stage_go && !(out_valid_ff && !rsp_ch.ready) |=> !out_valid_ff)
      else $error("result appeared without a parser step");

endmodule

`default_nettype wire
